/* rtl/core/aot_pkg.sv */
package aot_pkg;

  // averaging window and inverse-time stage delays
  localparam int unsigned AVG_DEPTH     = 16;
  localparam int unsigned MID_DELAY_MS  = 30000;
  localparam int unsigned FAST_DELAY_MS = 5000;

  localparam int unsigned CODE_W  = 12;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned AVG_W   = 16;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned LVL_W   = 18;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);
  localparam logic [FILL_W-1:0]  FILL_MAX  = FILL_W'(AVG_DEPTH);
  localparam logic [DELAY_W-1:0] MID_LIMIT  = DELAY_W'(MID_DELAY_MS);
  localparam logic [DELAY_W-1:0] FAST_LIMIT = DELAY_W'(FAST_DELAY_MS);
  localparam logic [DELAY_W-1:0] ELAPSED_TOP = '1;

  localparam logic [CODE_W-1:0]  RATED_RESET = 12'd4095;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

  // serial divider: (sum << 4) / fill
  localparam int unsigned DIVIDEND_W = SUM_W + 4;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // two-entry queues between the parts
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;
  localparam logic [QCNT_W-1:0] QDEPTH = QCNT_W'(2);

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  typedef enum logic {
    REG_RATED_LEVEL = 1'b0,
    REG_TRIP_DELAY  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] code;
  } job_t;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             trip;
    logic             clr;
  } result_t;

  typedef struct packed {
    logic [CODE_W-1:0]  rated_level;
    logic [DELAY_W-1:0] trip_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [FILL_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/aot_front.sv */
module aot_front import aot_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              mode_i,
  input  logic [CODE_W-1:0] sample_code_i,
  output logic              job_valid_o,
  output job_t              job_o,
  input  logic              job_pop_i
);

  job_t              entry_q [2];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;
  job_t              job_in;

  // classify the incoming item
  always_comb begin
    job_in.kind = mode_i ? KIND_TICK : KIND_SAMPLE;
    job_in.code = sample_code_i;
  end

  assign full_o      = (count_q == QDEPTH);
  assign job_valid_o = (count_q != '0);
  assign job_o       = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = job_pop_i && job_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= job_in;
  end

endmodule

/* rtl/core/aot_div.sv */
module aot_div import aot_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [FILL_W-1:0]     rem_q, divisor_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [FILL_W:0]       trial;
  logic                  fits;

  // one restoring step per cycle, dividend bits shift out at the top
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      quo_q     <= req_i.dividend;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? FILL_W'(trial - {1'b0, divisor_q}) : trial[FILL_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[AVG_W-1:0];

endmodule

/* rtl/core/aot_back.sv */
module aot_back import aot_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     job_valid_i,
  input  job_t     job_i,
  output logic     job_pop_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  output logic     res_push_o,
  output result_t  res_o,
  input  logic     res_full_i
);

  back_state_e        state_q, state_d;
  logic [CODE_W-1:0]  ring_q [AVG_DEPTH];
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d, sum_new;
  logic               over_q, over_d;
  logic [DELAY_W-1:0] elapsed_q, elapsed_d, base_elapsed, limit;
  logic               reported_q, reported_d;
  logic [AVG_W-1:0]   last_avg_q, last_avg_d;
  result_t            res_q, res_d;
  logic               ring_we, trip_c;
  logic [LVL_W-1:0]   avg_x, lvl1, lvl15, lvl2;

  assign sum_new = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(job_i.code);

  // stage thresholds, exact in 4-fraction-bit units
  assign avg_x = LVL_W'(last_avg_q);
  assign lvl1  = LVL_W'({cfg_i.rated_level, 4'b0});
  assign lvl15 = LVL_W'({cfg_i.rated_level, 4'b0}) + LVL_W'({cfg_i.rated_level, 3'b0});
  assign lvl2  = LVL_W'({cfg_i.rated_level, 5'b0});

  always_comb begin
    base_elapsed = over_q ? elapsed_q : '0;
    if (avg_x < lvl15)     limit = cfg_i.trip_delay_ms;
    else if (avg_x < lvl2) limit = MID_LIMIT;
    else                   limit = FAST_LIMIT;
    trip_c = (base_elapsed >= limit);
  end

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    over_d     = over_q;
    elapsed_d  = elapsed_q;
    reported_d = reported_q;
    last_avg_d = last_avg_q;
    res_d      = res_q;
    ring_we    = 1'b0;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = {sum_new, 4'b0};
    div_req_o.divisor  = (fill_q < FILL_MAX) ? fill_q + 1'b1 : fill_q;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_i.kind == KIND_TICK) begin
            if (over_q && elapsed_q != ELAPSED_TOP) elapsed_d = elapsed_q + 1'b1;
            res_d   = '{average: last_avg_q, trip: 1'b0, clr: 1'b0};
            state_d = ST_EMIT;
          end else begin
            ring_we         = 1'b1;
            sum_d           = sum_new;
            slot_d          = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
            fill_d          = div_req_o.divisor;
            div_req_o.start = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          last_avg_d = div_rsp_i.quotient;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_d = '{average: last_avg_q, trip: 1'b0, clr: 1'b0};
        if (avg_x >= lvl1) begin
          if (trip_c) begin
            res_d.trip = 1'b1;
            elapsed_d  = '0;
            over_d     = 1'b0;
            reported_d = 1'b1;
          end else begin
            elapsed_d = base_elapsed;
            over_d    = 1'b1;
          end
        end else begin
          over_d    = 1'b0;
          elapsed_d = '0;
          if (reported_q) begin
            res_d.clr  = 1'b1;
            reported_d = 1'b0;
          end
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_q     <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      over_q     <= 1'b0;
      elapsed_q  <= '0;
      reported_q <= 1'b0;
      last_avg_q <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) ring_q[i] <= '0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      fill_q     <= fill_d;
      sum_q      <= sum_d;
      over_q     <= over_d;
      elapsed_q  <= elapsed_d;
      reported_q <= reported_d;
      last_avg_q <= last_avg_d;
      if (ring_we) ring_q[slot_q] <= job_i.code;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* rtl/core/aot_outq.sv */
module aot_outq import aot_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_push_i,
  input  result_t          res_i,
  output logic             res_full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [AVG_W-1:0] average_value_o,
  output logic             trip_o,
  output logic             clear_o
);

  result_t           entry_q [2];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;
  result_t           head;

  assign res_full_o = (count_q == QDEPTH);
  assign empty_o    = (count_q == '0);
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head       = entry_q[rd_ptr_q];

  assign average_value_o = head.average;
  assign trip_o          = head.trip;
  assign clear_o         = head.clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= res_i;
  end

endmodule

/* rtl/core/averaged_overcurrent_trip.sv */
// channel   direction  handshake                       payload
// input     in         push / full                     mode_i, sample_code_i
// result    out        empty / pop                     average_value_o, trip_o, clear_o
// config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// a sample item goes from the head of the input queue to a waiting result by way
// of the ring update, the bit-serial divider (20 steps and the done flag), the
// decision and the hand-over; a tick item updates the stage timing and goes straight to the hand-over.
// the divider sets the rate
// reset is asynchronous and active low; it zeroes the ring, sum and timing and
// loads rated_level = 4095 and trip_delay_ms = 1000
// two-entry queues on each side let input and result sides stall independently

module averaged_overcurrent_trip import aot_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input item channel
  input  logic               push,
  output logic               full,
  input  logic               mode_i,
  input  logic [CODE_W-1:0]  sample_code_i,
  // result item channel
  output logic               empty,
  input  logic               pop,
  output logic [AVG_W-1:0]   average_value_o,
  output logic               trip_o,
  output logic               clear_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t     cfg_q;
  logic     cfg_we;
  reg_idx_e reg_idx;
  logic     job_valid, job_pop;
  job_t     job;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     res_push, res_full;
  result_t  res;

  // register file: one word per register, index taken from the word address
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rated_level   <= RATED_RESET;
      cfg_q.trip_delay_ms <= DELAY_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_RATED_LEVEL: cfg_q.rated_level   <= pwdata[CODE_W-1:0];
        REG_TRIP_DELAY:  cfg_q.trip_delay_ms <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RATED_LEVEL: prdata = DATA_W'(cfg_q.rated_level);
      REG_TRIP_DELAY:  prdata = DATA_W'(cfg_q.trip_delay_ms);
      default:         prdata = '0;
    endcase
  end

  // front: accepts and classifies items into a short queue
  aot_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .mode_i        (mode_i),
    .sample_code_i (sample_code_i),
    .job_valid_o   (job_valid),
    .job_o         (job),
    .job_pop_i     (job_pop)
  );

  // serial divider for the moving average
  aot_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // back: averaging ring, stage timing and trip / clear decisions
  aot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // result queue seen by the consumer
  aot_outq u_outq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_push_i      (res_push),
    .res_i           (res),
    .res_full_o      (res_full),
    .empty_o         (empty),
    .pop_i           (pop),
    .average_value_o (average_value_o),
    .trip_o          (trip_o),
    .clear_o         (clear_o)
  );

endmodule

/* rtl/core/aot_checker.sv */
module aot_checker import aot_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [AVG_W-1:0] average_value_o,
  input logic             trip_o,
  input logic             clear_o
);

  logic trip_open_q;

  // tracks whether a delivered trip has not yet been cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_open_q <= 1'b0;
    end else if (pop && !empty) begin
      if (trip_o)       trip_open_q <= 1'b1;
      else if (clear_o) trip_open_q <= 1'b0;
    end
  end

  a_trip_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(trip_o && clear_o))
    else $error("trip and clear in one item");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (average_value_o <= 16'd65520))
    else $error("average out of range");

  a_clear_after_trip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && clear_o) |-> trip_open_q)
    else $error("clear without an open trip");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(average_value_o) && $stable(trip_o)
                          && $stable(clear_o)))
    else $error("stalled result changed");

endmodule

bind averaged_overcurrent_trip aot_checker u_checker (.*);
